// ===== rtl/uwd_pkg.sv =====
package uwd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned N_CONT  = 3;

    localparam logic [CP_W-1:0]  REPL_CP    = 21'h00FFFD;
    localparam logic [CNT_W-1:0] MAX_AVAIL  = 3'd4;

    // sequence lengths
    localparam logic [CNT_W-1:0] LEN_1 = 3'd1;
    localparam logic [CNT_W-1:0] LEN_2 = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3 = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4 = 3'd4;

    // lead byte class masks
    localparam logic [7:0] MASK_E0 = 8'hE0;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_F8 = 8'hF8;
    localparam logic [7:0] PAT_C0  = 8'hC0;
    localparam logic [7:0] PAT_E0  = 8'hE0;
    localparam logic [7:0] PAT_F0  = 8'hF0;
    localparam logic [7:0] MASK_3F = 8'h3F;
    localparam logic [7:0] MASK_1F = 8'h1F;
    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic       cont;
        logic [5:0] bits;
    } t_lane;

    typedef struct packed {
        logic             bad;
        logic [CNT_W-1:0] len;
        logic [6:0]       bits;
    } t_lead;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [CNT_W-1:0] advance;
        logic             replaced;
    } t_result;

endpackage

// ===== rtl/uwd_lane.sv =====
module uwd_lane (
    input  logic [7:0]     i_byte,
    output uwd_pkg::t_lane o_lane
);
    import uwd_pkg::*;

    always_comb begin
        o_lane.cont = (i_byte[7:6] == CONT_TAG);
        o_lane.bits = 6'(i_byte & MASK_3F);
    end

endmodule

// ===== rtl/uwd_lead.sv =====
module uwd_lead (
    input  logic [7:0]     i_byte,
    output uwd_pkg::t_lead o_lead
);
    import uwd_pkg::*;

    always_comb begin
        o_lead.bad  = 1'b0;
        o_lead.len  = LEN_1;
        o_lead.bits = i_byte[6:0];
        if (!i_byte[7]) begin
            o_lead.len  = LEN_1;
            o_lead.bits = i_byte[6:0];
        end else if ((i_byte & MASK_E0) == PAT_C0) begin
            o_lead.len  = LEN_2;
            o_lead.bits = 7'(i_byte & MASK_1F);
        end else if ((i_byte & MASK_F0) == PAT_E0) begin
            o_lead.len  = LEN_3;
            o_lead.bits = {3'b000, i_byte[3:0]};
        end else if ((i_byte & MASK_F8) == PAT_F0) begin
            o_lead.len  = LEN_4;
            o_lead.bits = {4'b0000, i_byte[2:0]};
        end else begin
            o_lead.bad  = 1'b1;
            o_lead.len  = LEN_1;
            o_lead.bits = 7'b0;
        end
    end

endmodule

// ===== rtl/uwd_merge.sv =====
module uwd_merge (
    input  uwd_pkg::t_lead                   i_lead,
    input  uwd_pkg::t_lane [uwd_pkg::N_CONT-1:0] i_lanes,
    input  logic [uwd_pkg::CNT_W-1:0]        i_bytes_left,
    output uwd_pkg::t_result                 o_result
);
    import uwd_pkg::*;

    logic [CNT_W-1:0] avail;

    assign avail = (i_bytes_left > MAX_AVAIL) ? MAX_AVAIL : i_bytes_left;

    always_comb begin
        o_result.code_point = REPL_CP;
        o_result.advance    = i_lead.len;
        o_result.replaced   = 1'b1;
        if (avail == 3'd0) begin
            o_result.advance = 3'd0;
        end else if (i_lead.bad) begin
            o_result.advance = LEN_1;
        end else if (i_lead.len > avail) begin
            o_result.advance = avail;
        end else if (i_lead.len >= LEN_2 && !i_lanes[0].cont) begin
            o_result.advance = LEN_1;
        end else if (i_lead.len >= LEN_3 && !i_lanes[1].cont) begin
            o_result.advance = LEN_2;
        end else if (i_lead.len == LEN_4 && !i_lanes[2].cont) begin
            o_result.advance = LEN_3;
        end else begin
            o_result.replaced = 1'b0;
            case (i_lead.len)
                LEN_1: o_result.code_point = {14'b0, i_lead.bits};
                LEN_2: o_result.code_point = {10'b0, i_lead.bits[4:0], i_lanes[0].bits};
                LEN_3: o_result.code_point = {5'b0, i_lead.bits[3:0], i_lanes[0].bits,
                                              i_lanes[1].bits};
                LEN_4: o_result.code_point = {i_lead.bits[2:0], i_lanes[0].bits,
                                              i_lanes[1].bits, i_lanes[2].bits};
                default: o_result.code_point = REPL_CP;
            endcase
        end
    end

endmodule

// ===== rtl/utf8_window_decoder.sv =====
// UTF-8 window decoder. Each input transaction carries the byte at the read
// position, the three bytes after it and the count of bytes left (values
// above four count as four). Each transaction yields exactly one output
// transaction: the decoded code point, how far to move the read position,
// and a replaced flag. Errors (empty buffer, bad lead, sequence running past
// the buffer end, bad continuation byte) return U+FFFD with replaced set;
// overlong forms and surrogates decode as-is. Stage 1 registers the input,
// the output registers the result. Throughput is one transaction per clock
// unless the receiver stalls, set by the two-stage pipeline (lane stage, then
// merge stage) each of which accepts a new transaction whenever it is empty or its contents move on.
module utf8_window_decoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_lead_byte,
    input  logic [7:0]                i_second_byte,
    input  logic [7:0]                i_third_byte,
    input  logic [7:0]                i_fourth_byte,
    input  logic [uwd_pkg::CNT_W-1:0] i_bytes_left,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [uwd_pkg::CP_W-1:0]  o_code_point,
    output logic [uwd_pkg::CNT_W-1:0] o_advance,
    output logic                      o_replaced
);
    import uwd_pkg::*;

    // ---- lane stage: lead classifier plus one lane per continuation byte
    t_lead                 lead;
    t_lane [N_CONT-1:0]    lanes;
    logic  [7:0]           cont_bytes [N_CONT];

    assign cont_bytes[0] = i_second_byte;
    assign cont_bytes[1] = i_third_byte;
    assign cont_bytes[2] = i_fourth_byte;

    uwd_lead u_lead (
        .i_byte (i_lead_byte),
        .o_lead (lead)
    );

    for (genvar g = 0; g < N_CONT; g++) begin : g_lane
        uwd_lane u_lane (
            .i_byte (cont_bytes[g]),
            .o_lane (lanes[g])
        );
    end

    // stage 1 registers
    logic                  r_s1_valid;
    t_lead                 r_s1_lead;
    t_lane [N_CONT-1:0]    r_s1_lanes;
    logic  [CNT_W-1:0]     r_s1_left;

    // stage 2 (output) registers
    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic out_load;   // output register may take a new transaction
    logic s1_load;    // stage 1 may take a new transaction

    assign out_load = !r_out_valid || !i_stall;
    assign s1_load  = !r_s1_valid || out_load;
    assign o_stall  = !s1_load;

    // ---- merge stage: priority of error cases, then code point assembly
    uwd_merge u_merge (
        .i_lead       (r_s1_lead),
        .i_lanes      (r_s1_lanes),
        .i_bytes_left (r_s1_left),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_s1_lead  <= lead;
            r_s1_lanes <= lanes;
            r_s1_left  <= i_bytes_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_out.code_point;
    assign o_advance    = r_out.advance;
    assign o_replaced   = r_out.replaced;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uwd_pkg::*;

    // Cycles with no transaction on either side before the run is abandoned.
    // The longest correct quiet spell is the forced receiver hold-off below.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 150;

    // ------------------------------------------------------------------
    // Clock, reset and DUT inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic [7:0]       i_lead_byte   = '0;
    logic [7:0]       i_second_byte = '0;
    logic [7:0]       i_third_byte  = '0;
    logic [7:0]       i_fourth_byte = '0;
    logic [CNT_W-1:0] i_bytes_left  = '0;
    logic             i_stall       = 1'b0;

    logic             o_stall;
    logic             o_valid;
    logic [CP_W-1:0]  o_code_point;
    logic [CNT_W-1:0] o_advance;
    logic             o_replaced;

    // Decodes predicted at input acceptance, oldest first.
    t_result     pending_decodes[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    // Knobs shared between the test tasks and the receiver process.
    bit tx_gaps_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    bit long_hold_req = 1'b0;
    int hold_left     = 0;

    always #5 i_clk = ~i_clk;

    utf8_window_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_lead_byte   (i_lead_byte),
        .i_second_byte (i_second_byte),
        .i_third_byte  (i_third_byte),
        .i_fourth_byte (i_fourth_byte),
        .i_bytes_left  (i_bytes_left),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_advance     (o_advance),
        .o_replaced    (o_replaced)
    );

    // ------------------------------------------------------------------
    // Decode predictor: one window in, one result out, no state.
    // ------------------------------------------------------------------
    function automatic t_result predict_decode(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [CNT_W-1:0] left);
        logic [7:0]       win [4];
        logic [CNT_W-1:0] avail;
        logic [CNT_W-1:0] len;
        logic [CP_W-1:0]  cp;
        t_result          res;
        int               k;

        win[0] = b0;
        win[1] = b1;
        win[2] = b2;
        win[3] = b3;
        // counts above four saturate
        avail = (left > MAX_AVAIL) ? MAX_AVAIL : left;
        res.code_point = REPL_CP;
        res.advance    = '0;
        res.replaced   = 1'b1;

        // empty buffer: replacement, no movement
        if (avail == '0)
            return res;

        casez (b0)
            8'b0???????: begin
                cp  = CP_W'(b0[6:0]);
                len = LEN_1;
            end
            8'b110?????: begin
                cp  = CP_W'(b0[4:0]);
                len = LEN_2;
            end
            8'b1110????: begin
                cp  = CP_W'(b0[3:0]);
                len = LEN_3;
            end
            8'b11110???: begin
                cp  = CP_W'(b0[2:0]);
                len = LEN_4;
            end
            default: begin
                // stray continuation or 11111xxx lead: skip one byte
                res.advance = 3'd1;
                return res;
            end
        endcase

        // sequence runs past the buffer end: jump to the end
        if (len > avail) begin
            res.advance = avail;
            return res;
        end

        for (k = 1; k < len; k++) begin
            // stop just before the first byte that is not a continuation
            if (win[k][7:6] != CONT_TAG) begin
                res.advance = CNT_W'(k);
                return res;
            end
            cp = {cp[CP_W-7:0], win[k][5:0]};
        end

        res.code_point = cp;
        res.advance    = len;
        res.replaced   = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check the output transaction against the oldest
    // prediction, then record the input transaction of this edge.
    // Values are sampled as they stood before the edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_decodes.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected output: cp=%h adv=%0d rep=%b",
                                 o_code_point, o_advance, o_replaced);
                    mismatch_count++;
                end else begin
                    want = pending_decodes.pop_front();
                    if (o_code_point !== want.code_point || o_advance !== want.advance ||
                        o_replaced !== want.replaced) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected cp=%h adv=%0d rep=%b, got cp=%h adv=%0d rep=%b",
                                     want.code_point, want.advance, want.replaced,
                                     o_code_point, o_advance, o_replaced);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && !o_stall)
                pending_decodes.push_back(predict_decode(i_lead_byte, i_second_byte,
                                                         i_third_byte, i_fourth_byte,
                                                         i_bytes_left));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts (mostly short, a few long), plus one
    // forced hold-off on request that backs the pipe up into the input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            i_stall   <= 1'b1;
            hold_left <= LONG_HOLD - 1;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            i_stall   <= 1'b1;
            hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: no transaction on either side for too long ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one window and hold it until the DUT takes it. Valid stays
    // high on return so back-to-back transactions need no extra edge.
    task automatic send_window(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic [CNT_W-1:0] left);
        i_valid       <= 1'b1;
        i_lead_byte   <= b0;
        i_second_byte <= b1;
        i_third_byte  <= b2;
        i_fourth_byte <= b3;
        i_bytes_left  <= left;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    // Optional idle gap after an accepted transaction.
    task automatic sender_idle();
        int unsigned n;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_and_idle(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [7:0] b3,
                                 input logic [CNT_W-1:0] left);
        send_window(b0, b1, b2, b3, left);
        sender_idle();
    endtask

    // Random window: mostly well-formed sequences with random payload bits,
    // some broken ones (bad continuation or truncated buffer), rest noise.
    task automatic send_random_window();
        logic [7:0]       w [4];
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] len;
        int unsigned      kind;
        int unsigned      k;

        kind = $urandom_range(0, 99);
        for (k = 0; k < 4; k++)
            w[k] = 8'($urandom);
        left = CNT_W'($urandom_range(0, 7));

        if (kind < 80) begin
            len = (kind < 65) ? CNT_W'($urandom_range(1, 4)) : CNT_W'($urandom_range(2, 4));
            case (len)
                LEN_1:   w[0][7]   = 1'b0;
                LEN_2:   w[0][7:5] = 3'b110;
                LEN_3:   w[0][7:4] = 4'b1110;
                default: w[0][7:3] = 5'b11110;
            endcase
            for (k = 1; k < len; k++)
                w[k][7:6] = CONT_TAG;
            left = CNT_W'($urandom_range(len, 7));
            if (kind >= 65) begin
                if ($urandom_range(0, 1) == 0) begin
                    k = $urandom_range(1, len - 1);
                    do
                        w[k][7:6] = 2'($urandom);
                    while (w[k][7:6] == CONT_TAG);
                end else begin
                    left = CNT_W'($urandom_range(1, len - 1));
                end
            end
        end
        send_and_idle(w[0], w[1], w[2], w[3], left);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every sequence length and every error path.
    task automatic test_directed();
        send_and_idle(8'h41, 8'hFF, 8'h00, 8'hAA, 3'd0);  // empty buffer
        send_and_idle(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1);  // NUL, trailing bytes ignored
        send_and_idle(8'h7F, 8'h80, 8'h80, 8'h80, 3'd4);  // top of ASCII
        send_and_idle(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);  // stray continuation as lead
        send_and_idle(8'hBF, 8'h00, 8'h00, 8'h00, 3'd2);
        send_and_idle(8'hF8, 8'h80, 8'h80, 8'h80, 3'd4);  // 11111xxx lead
        send_and_idle(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
        send_and_idle(8'hC2, 8'hA9, 8'h00, 8'h00, 3'd2);  // two bytes
        send_and_idle(8'hC0, 8'h80, 8'h00, 8'h00, 3'd4);  // overlong NUL, accepted
        send_and_idle(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd3);
        send_and_idle(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd3);  // three bytes
        send_and_idle(8'hED, 8'hA0, 8'h80, 8'h00, 3'd4);  // surrogate, accepted
        send_and_idle(8'hEF, 8'hBF, 8'hBF, 8'h41, 3'd4);
        send_and_idle(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4);  // four bytes
        send_and_idle(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4);  // largest code point
        send_and_idle(8'hC2, 8'hA9, 8'h00, 8'h00, 3'd1);  // runs past buffer end
        send_and_idle(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2);
        send_and_idle(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3);
        send_and_idle(8'hC2, 8'h41, 8'h00, 8'h00, 3'd4);  // bad continuation, each offset
        send_and_idle(8'hE2, 8'h82, 8'hC1, 8'h00, 3'd4);
        send_and_idle(8'hF0, 8'h9F, 8'h98, 8'hC0, 3'd4);
        send_and_idle(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd5);  // counts above four
        send_and_idle(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd6);
        send_and_idle(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd7);
    endtask

    // Random windows with idling on both sides.
    task automatic test_mixed_traffic(input int unsigned count);
        repeat (count) send_random_window();
    endtask

    // Full-rate stretch: no sender gaps, no receiver stalls.
    task automatic test_steady_stream(input int unsigned count);
        tx_gaps_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count) send_random_window();
        tx_gaps_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps
    // offering, so the pipe fills and the input stall comes up.
    task automatic test_long_hold(input int unsigned count);
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        repeat (count) send_random_window();
        tx_gaps_on = 1'b1;
    endtask

    // Sender stops mid-run until every pending decode has come out.
    task automatic test_drain_pause(input int unsigned count);
        repeat (count / 2) send_random_window();
        i_valid <= 1'b0;
        // one edge so the last accepted transaction is already queued
        @(posedge i_clk);
        wait (pending_decodes.size() == 0);
        @(posedge i_clk);
        repeat (count - count / 2) send_random_window();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_mixed_traffic(800);
        test_steady_stream(300);
        test_long_hold(150);
        test_drain_pause(400);

        // let the pipe empty, then a few edges to catch stray outputs
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_decodes.size() == 0);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/uwd_pkg.sv
rtl/uwd_lane.sv
rtl/uwd_lead.sv
rtl/uwd_merge.sv
rtl/utf8_window_decoder.sv
bench/tb_top.sv
